FILE: rtl/text_glyph_placement_macros.svh
// Assertion macros for the glyph placement block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef TEXT_GLYPH_PLACEMENT_MACROS_SVH
`define TEXT_GLYPH_PLACEMENT_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define TGP_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define TGP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tgp_pkg.sv
// Shared types, codes and helpers of the glyph placement block.
// No dependencies; used by tgp_cursor and text_glyph_placement.
package tgp_pkg;

  localparam int unsigned FIRST_CODE   = 32;
  localparam logic [6:0]  NEWLINE_CODE = 7'd10;
  localparam logic [15:0] CURSOR_START = 16'd128;   // 4.0 in 11.5
  localparam logic [15:0] SAT_MAX      = 16'hFFFF;
  localparam int unsigned GLYPH_W      = 11;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BEGIN = 2'd1,
    ACT_CHAR  = 2'd2,
    ACT_END   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_SIZE_INDEX  = 2'd0,
    CFG_ASCENT      = 2'd1,
    CFG_LINE_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_BEGIN   = 2'd0,
    OP_GLYPH   = 2'd1,
    OP_NEWLINE = 2'd2,
    OP_END     = 2'd3
  } op_e;

  typedef enum logic {
    KIND_GLYPH   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  // Request held in the layout stage while its advance is read.
  typedef struct packed {
    op_e                  op;
    logic [GLYPH_W-1:0]   glyph_index;
    logic [15:0]          palette;
    logic [15:0]          start_extent;
  } item_t;

  typedef struct packed {
    kind_e                kind;
    logic [15:0]          pos_x;
    logic [15:0]          pos_y;
    logic [GLYPH_W-1:0]   glyph_index;
    logic [15:0]          palette;
    logic [15:0]          instance_count;
    logic [15:0]          max_width;
    logic [15:0]          total_height;
  } res_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? SAT_MAX : s[15:0];
  endfunction

endpackage

FILE: rtl/tgp_adv_mem.sv
// Advance table: one write port, one registered read port.
// Depends on nothing; sized by the top level.
module tgp_adv_mem #(
  parameter int unsigned DEPTH  = 1520,
  parameter int unsigned ADDR_W = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [15:0]       wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [15:0]       rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold the read data while the consumer stalls.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tgp_cursor.sv
// Cursor and per-string sums; forms the glyph and summary results.
// Depends on tgp_pkg.
module tgp_cursor import tgp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  item_t       item_i,
  input  logic [15:0] adv_i,
  input  logic [10:0] ascent_i,
  input  logic [10:0] line_height_i,
  output logic        has_res_o,
  output res_t        res_o
);

  logic [15:0] x_q, x_d, y_q, y_d, lw_q, lw_d, wl_q, wl_d, hs_q, hs_d, gc_q, gc_d;
  logic [15:0] step, wl_fold;

  assign step    = {line_height_i, 5'b0};
  assign wl_fold = (lw_q > wl_q) ? lw_q : wl_q;

  always_comb begin
    x_d  = x_q;
    y_d  = y_q;
    lw_d = lw_q;
    wl_d = wl_q;
    hs_d = hs_q;
    gc_d = gc_q;
    res_o = '0;
    has_res_o = 1'b0;
    case (item_i.op)
      OP_BEGIN: begin
        x_d  = CURSOR_START;
        y_d  = sat_add16(CURSOR_START, {ascent_i, 5'b0});
        lw_d = '0;
        wl_d = item_i.start_extent;
        hs_d = '0;
        gc_d = '0;
      end
      OP_GLYPH: begin
        has_res_o         = 1'b1;
        res_o.kind        = KIND_GLYPH;
        res_o.pos_x       = x_q;
        res_o.pos_y       = y_q;
        res_o.glyph_index = item_i.glyph_index;
        res_o.palette     = item_i.palette;
        x_d  = sat_add16(x_q, adv_i);
        lw_d = sat_add16(lw_q, adv_i);
        gc_d = sat_add16(gc_q, 16'd1);
      end
      OP_NEWLINE: begin
        x_d  = CURSOR_START;
        y_d  = sat_add16(y_q, step);
        wl_d = wl_fold;
        lw_d = '0;
        hs_d = sat_add16(hs_q, step);
      end
      OP_END: begin
        wl_d = wl_fold;
        // Count the open line only if its width is not zero.
        if (lw_q != '0) begin
          hs_d = sat_add16(hs_q, step);
        end
        lw_d = '0;
        has_res_o            = 1'b1;
        res_o.kind           = KIND_SUMMARY;
        res_o.instance_count = gc_q;
        res_o.max_width      = wl_d;
        res_o.total_height   = hs_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q  <= '0;
      y_q  <= '0;
      lw_q <= '0;
      wl_q <= '0;
      hs_q <= '0;
      gc_q <= '0;
    end else if (fire_i) begin
      x_q  <= x_d;
      y_q  <= y_d;
      lw_q <= lw_d;
      wl_q <= wl_d;
      hs_q <= hs_d;
      gc_q <= gc_d;
    end
  end

endmodule

FILE: rtl/text_glyph_placement.sv
// Glyph placement top level: decode, advance table, layout stage, output register.
// Depends on tgp_pkg, tgp_adv_mem, tgp_cursor and the assertion macros.
//
// Takes one request per clock cycle. A taken request is registered in the layout
// stage. While the request is offered it is decoded, and its advance is read
// into the memory's output register as it is taken. In the layout stage the
// cursor and the string sums are updated and the result is loaded into the
// output register. Table loads write the memory in the cycle they are taken, so
// a character that follows a load at once already sees the new advance. Loads,
// begins, newlines and dropped codes give no result. Back-pressure on the result
// side stalls the layout stage, and then the input, only once a result is
// waiting in it.
`include "text_glyph_placement_macros.svh"

module text_glyph_placement import tgp_pkg::*; #(
  parameter int unsigned SIZE_ROWS   = 16,
  parameter int unsigned GLYPH_SLOTS = 95
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // char_code[6:0], palette_in[22:7], load_size[26:23], advance_in[42:27],
  // start_extent[58:43], zero[63:59]
  input  logic [63:0]  s_axis_tdata,
  // action[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[15:0], pos_y[31:16], glyph_index[42:32], palette_out[58:43],
  // instance_count[74:59], max_width[90:75], total_height[106:91], zero[111:107]
  output logic [111:0] m_axis_tdata,
  // kind[0]
  output logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [10:0]  cfg_data_i
);

  localparam int unsigned DEPTH  = SIZE_ROWS * GLYPH_SLOTS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration
  logic [3:0]  size_q;
  logic [10:0] ascent_q, line_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= '0;
      ascent_q <= '0;
      line_h_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIZE_INDEX:  size_q   <= cfg_data_i[3:0];
        CFG_ASCENT:      ascent_q <= cfg_data_i;
        CFG_LINE_HEIGHT: line_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Decode
  action_e     act;
  logic [6:0]  code;
  logic [15:0] palette_in, advance_in, start_extent;
  logic [3:0]  load_size;
  logic        accept, load_ok, printable, is_newline, enter;
  logic [6:0]  slot;
  logic [6:0]  row;
  logic [ADDR_W-1:0] waddr, raddr;
  item_t       item_d;

  assign act          = action_e'(s_axis_tuser);
  assign code         = s_axis_tdata[6:0];
  assign palette_in   = s_axis_tdata[22:7];
  assign load_size    = s_axis_tdata[26:23];
  assign advance_in   = s_axis_tdata[42:27];
  assign start_extent = s_axis_tdata[58:43];

  assign accept     = s_axis_tvalid & s_axis_tready;
  assign load_ok    = ({1'b0, code} < 8'(GLYPH_SLOTS)) && ({3'b0, load_size} < 7'(SIZE_ROWS));
  assign is_newline = (code == NEWLINE_CODE);
  assign printable  = ({1'b0, code} >= 8'(FIRST_CODE))
                      && ({1'b0, code} < 8'(FIRST_CODE + GLYPH_SLOTS));
  assign slot       = code - 7'(FIRST_CODE);
  // Clamp the configured size row to the table.
  assign row        = ({3'b0, size_q} >= 7'(SIZE_ROWS)) ? 7'(SIZE_ROWS - 1) : {3'b0, size_q};
  assign waddr      = ADDR_W'(32'(load_size) * 32'(GLYPH_SLOTS) + 32'(code));
  assign raddr      = ADDR_W'(32'(row) * 32'(GLYPH_SLOTS) + 32'(slot));

  always_comb begin
    item_d              = '0;
    item_d.glyph_index  = GLYPH_W'(32'(row) * 32'(GLYPH_SLOTS) + 32'(slot));
    item_d.palette      = (palette_in == SAT_MAX) ? 16'd0 : palette_in;
    item_d.start_extent = start_extent;
    enter               = 1'b0;
    case (act)
      ACT_BEGIN: begin
        item_d.op = OP_BEGIN;
        enter     = 1'b1;
      end
      ACT_CHAR: begin
        item_d.op = is_newline ? OP_NEWLINE : OP_GLYPH;
        enter     = is_newline | printable;
      end
      ACT_END: begin
        item_d.op = OP_END;
        enter     = 1'b1;
      end
      default: item_d.op = OP_BEGIN;
    endcase
  end

  // Advance table
  logic [15:0] adv;

  tgp_adv_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_adv_mem (
    .clk_i   (clk_i),
    .we_i    (accept && (act == ACT_LOAD) && load_ok),
    .waddr_i (waddr),
    .wdata_i (advance_in),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (adv)
  );

  // Layout stage
  logic  s1_valid_q;
  item_t s1_item_q;
  logic  s1_has_res, s1_fire, out_free;
  res_t  s1_res;

  tgp_cursor u_cursor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (s1_fire),
    .item_i        (s1_item_q),
    .adv_i         (adv),
    .ascent_i      (ascent_q),
    .line_height_i (line_h_q),
    .has_res_o     (s1_has_res),
    .res_o         (s1_res)
  );

  logic out_valid_q;
  res_t out_q;

  assign out_free      = ~out_valid_q | m_axis_tready;
  assign s1_fire       = s1_valid_q & (~s1_has_res | out_free);
  assign s_axis_tready = ~s1_valid_q | s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= accept & enter;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= item_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_has_res) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_has_res) begin
      out_q <= s1_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {5'b0, out_q.total_height, out_q.max_width, out_q.instance_count,
                          out_q.palette, out_q.glyph_index, out_q.pos_y, out_q.pos_x};

  // Checks
  `TGP_ASSERT(a_stall_blocks_input,
    !(s1_valid_q && s1_has_res && out_valid_q && !m_axis_tready) || !s_axis_tready,
    "input taken while the layout stage is stalled")
  `TGP_ASSERT_NEXT(a_result_lands, s1_fire && s1_has_res, m_axis_tvalid,
    "result lost between layout stage and output register")
  `TGP_ASSERT(a_summary_no_pos,
    !(m_axis_tvalid && (out_q.kind == KIND_SUMMARY)) || (m_axis_tdata[58:0] == '0),
    "summary result carries glyph fields")

endmodule

FILE: sim/tb_text_glyph_placement.sv
// Testbench for text_glyph_placement: a layout predictor built into the bench tracks
// the cursor, line sums and advance table, and checks every glyph and summary result.
// Depends on tgp_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_text_glyph_placement;
  import tgp_pkg::*;

  localparam int unsigned SIZE_ROWS      = 16;
  localparam int unsigned GLYPH_SLOTS    = 95;
  localparam int unsigned TABLE_DEPTH    = SIZE_ROWS * GLYPH_SLOTS;
  localparam int unsigned PIPE_DRAIN     = 4;
  localparam int unsigned RX_HOLD        = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // char_code[6:0], palette_in[22:7], load_size[26:23], advance_in[42:27],
  // start_extent[58:43], zero[63:59]
  logic [63:0]  s_axis_tdata  = '0;
  // action[1:0]
  logic [1:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // pos_x[15:0], pos_y[31:16], glyph_index[42:32], palette_out[58:43],
  // instance_count[74:59], max_width[90:75], total_height[106:91], zero[111:107]
  logic [111:0] m_axis_tdata;
  // kind[0]
  logic         m_axis_tuser;
  logic         cfg_we_i      = 1'b0;
  logic [1:0]   cfg_idx_i     = '0;
  logic [10:0]  cfg_data_i    = '0;

  text_glyph_placement #(
    .SIZE_ROWS  (SIZE_ROWS),
    .GLYPH_SLOTS(GLYPH_SLOTS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Layout state as the block should hold it
  logic [15:0] adv_mem [TABLE_DEPTH];
  bit          adv_loaded [TABLE_DEPTH];
  logic [3:0]  cfg_row;
  logic [10:0] cfg_ascent;
  logic [10:0] cfg_line_h;
  logic [15:0] cur_x, cur_y, line_w, widest, height_acc, glyph_cnt;

  res_t        glyph_results_q [$];
  int unsigned mismatches    = 0;
  int unsigned requests_sent = 0;
  int unsigned phase_no      = 0;
  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  int unsigned hold_asked    = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned stall_cycles  = 0;

  initial begin
    cfg_row    = '0;
    cfg_ascent = '0;
    cfg_line_h = '0;
    cur_x      = '0;
    cur_y      = '0;
    line_w     = '0;
    widest     = '0;
    height_acc = '0;
    glyph_cnt  = '0;
  end

  function automatic logic [15:0] sat16(input int unsigned a, input int unsigned b);
    return (a + b > 65535) ? 16'hFFFF : 16'(a + b);
  endfunction

  function automatic void lay_out_request(input action_e act, input logic [6:0] code,
      input logic [15:0] pal, input logic [3:0] lsize, input logic [15:0] adv,
      input logic [15:0] start);
    res_t        r;
    int unsigned row;
    int unsigned idx;
    logic [15:0] step;
    r    = '0;
    step = {cfg_line_h, 5'b0};
    row  = (cfg_row >= SIZE_ROWS) ? SIZE_ROWS - 1 : cfg_row;
    case (act)
      ACT_LOAD: begin
        // out-of-range slots and rows leave the table alone
        if (code < GLYPH_SLOTS && lsize < SIZE_ROWS) begin
          idx             = lsize * GLYPH_SLOTS + code;
          adv_mem[idx]    = adv;
          adv_loaded[idx] = 1'b1;
        end
      end
      ACT_BEGIN: begin
        cur_x      = CURSOR_START;
        cur_y      = sat16(CURSOR_START, {cfg_ascent, 5'b0});
        line_w     = '0;
        widest     = start;
        height_acc = '0;
        glyph_cnt  = '0;
      end
      ACT_CHAR: begin
        if (code == NEWLINE_CODE) begin
          cur_x      = CURSOR_START;
          cur_y      = sat16(cur_y, step);
          if (line_w > widest) widest = line_w;
          line_w     = '0;
          height_acc = sat16(height_acc, step);
        end else if (code >= FIRST_CODE && code < FIRST_CODE + GLYPH_SLOTS) begin
          idx           = row * GLYPH_SLOTS + (code - FIRST_CODE);
          r.kind        = KIND_GLYPH;
          r.pos_x       = cur_x;
          r.pos_y       = cur_y;
          r.glyph_index = GLYPH_W'(idx);
          r.palette     = 16'(pal % 65535);
          cur_x         = sat16(cur_x, adv_mem[idx]);
          line_w        = sat16(line_w, adv_mem[idx]);
          glyph_cnt     = sat16(glyph_cnt, 1);
          glyph_results_q.push_back(r);
        end
      end
      default: begin
        // end of string: fold the open line, count it only if its width is not zero
        if (line_w > widest) widest = line_w;
        if (line_w != 0) height_acc = sat16(height_acc, step);
        line_w           = '0;
        r.kind           = KIND_SUMMARY;
        r.instance_count = glyph_cnt;
        r.max_width      = widest;
        r.total_height   = height_acc;
        glyph_results_q.push_back(r);
      end
    endcase
  endfunction

  task automatic send_request(input action_e act, input logic [6:0] code,
      input logic [15:0] pal, input logic [3:0] lsize, input logic [15:0] adv,
      input logic [15:0] start);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {5'b0, start, adv, lsize, pal, code};
    do @(posedge clk_i); while (!s_axis_tready);
    lay_out_request(act, code, pal, lsize, adv, start);
    requests_sent++;
  endtask

  task automatic load_advance(input logic [3:0] row, input logic [6:0] slot,
      input logic [15:0] adv);
    send_request(ACT_LOAD, slot, 16'($urandom), row, adv, 16'($urandom));
  endtask

  task automatic send_char(input logic [6:0] code, input logic [15:0] pal);
    send_request(ACT_CHAR, code, pal, 4'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic begin_string(input logic [15:0] start);
    send_request(ACT_BEGIN, 7'($urandom), 16'($urandom), 4'($urandom), 16'($urandom), start);
  endtask

  task automatic end_string();
    send_request(ACT_END, 7'($urandom), 16'($urandom), 4'($urandom), 16'($urandom),
                 16'($urandom));
  endtask

  // Only codes whose advance in the active row has been loaded
  function automatic logic [6:0] pick_printable();
    int unsigned slot;
    do slot = $urandom_range(0, GLYPH_SLOTS - 1);
    while (!adv_loaded[cfg_row * GLYPH_SLOTS + slot]);
    return 7'(FIRST_CODE + slot);
  endfunction

  function automatic logic [6:0] pick_nonprintable();
    int unsigned c;
    c = $urandom_range(0, FIRST_CODE);
    if (c == FIRST_CODE) return 7'(FIRST_CODE + GLYPH_SLOTS);
    if (c == NEWLINE_CODE) return NEWLINE_CODE + 7'd1;
    return 7'(c);
  endfunction

  function automatic logic [15:0] pick_advance();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047));
  endfunction

  // Drop the request and let the pipeline empty before touching registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (glyph_results_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  task automatic set_layout(input logic [3:0] size, input logic [10:0] ascent,
      input logic [10:0] line_h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SIZE_INDEX;
    cfg_data_i <= 11'(size);
    @(posedge clk_i);
    cfg_row    = size;
    cfg_idx_i  <= CFG_ASCENT;
    cfg_data_i <= ascent;
    @(posedge clk_i);
    cfg_ascent = ascent;
    cfg_idx_i  <= CFG_LINE_HEIGHT;
    cfg_data_i <= line_h;
    @(posedge clk_i);
    cfg_line_h = line_h;
    cfg_we_i   <= 1'b0;
  endtask

  task automatic send_string(input int unsigned max_chars);
    int unsigned n;
    int unsigned roll;
    begin_string(($urandom_range(0, 99) < 70) ? 16'd0 : 16'($urandom));
    n = $urandom_range(1, max_chars);
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) send_char(pick_printable(), 16'($urandom));
      else if (roll < 93) send_char(NEWLINE_CODE, 16'($urandom));
      else send_char(pick_nonprintable(), 16'($urandom));
    end
    end_string();
  endtask

  task automatic run_phase(input int unsigned n_requests);
    int unsigned stop_at;
    int unsigned roll;
    settle();
    case (phase_no % 3)
      0:       set_layout(4'd15, 11'd2047, 11'd2047);
      1:       set_layout(4'd0, 11'd0, 11'd0);
      default: set_layout(4'($urandom), 11'($urandom), 11'($urandom));
    endcase
    phase_no++;
    repeat (16) load_advance(cfg_row, 7'($urandom_range(0, GLYPH_SLOTS - 1)), pick_advance());
    stop_at = requests_sent + n_requests;
    while (requests_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) send_string(24);
      else if (roll < 85) load_advance(4'($urandom), 7'($urandom), pick_advance());
      // stray characters, lone ends and begins break up the strings
      else if (roll < 92) send_char(roll[0] ? pick_printable() : pick_nonprintable(),
                                    16'($urandom));
      else if (roll < 96) end_string();
      else begin_string(16'($urandom));
    end
  endtask

  task automatic test_directed_cases();
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_layout(4'd0, 11'd12, 11'd16);
    load_advance(4'd0, 7'd0, 16'h0100);
    load_advance(4'd0, 7'(GLYPH_SLOTS - 1), 16'hFFFF);
    load_advance(4'd0, 7'(GLYPH_SLOTS), 16'd5);
    load_advance(4'd15, 7'h7F, 16'd7);
    // glyph and summary straight out of reset, without a begin
    send_char(7'(FIRST_CODE), 16'hFFFF);
    end_string();
    begin_string(16'd0);
    send_char(7'(FIRST_CODE + GLYPH_SLOTS - 1), 16'hFFFE);
    send_char(7'(FIRST_CODE + GLYPH_SLOTS - 1), 16'h0000);
    send_char(7'd0, 16'h5A5A);
    send_char(7'(FIRST_CODE - 1), 16'hA5A5);
    send_char(7'(FIRST_CODE + GLYPH_SLOTS), 16'h1234);
    send_char(NEWLINE_CODE, 16'h0000);
    send_char(7'(FIRST_CODE), 16'd1234);
    end_string();
    end_string();
    begin_string(16'hFFFF);
    send_char(NEWLINE_CODE, 16'h0000);
    send_char(NEWLINE_CODE, 16'h0000);
    end_string();
  endtask

  task automatic test_random_layout(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (2) run_phase(90);
  endtask

  task automatic test_receiver_stall();
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_layout(4'd3, 11'd20, 11'd24);
    repeat (8) load_advance(4'd3, 7'($urandom_range(0, GLYPH_SLOTS - 1)), pick_advance());
    begin_string(16'd0);
    hold_asked++;
    repeat (48) send_char(pick_printable(), 16'($urandom));
    end_string();
  endtask

  // Result side: random ready, or a long hold when one is asked for
  always @(posedge clk_i) begin
    if (hold_asked != holds_served) begin
      holds_served  <= hold_asked;
      hold_left     <= RX_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (glyph_results_q.size() == 0) begin
        $error("unexpected result: kind %0d, data %h", m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = glyph_results_q.pop_front();
        check_field("kind", want.kind, m_axis_tuser);
        check_field("pos_x", want.pos_x, m_axis_tdata[15:0]);
        check_field("pos_y", want.pos_y, m_axis_tdata[31:16]);
        check_field("glyph_index", want.glyph_index, m_axis_tdata[42:32]);
        check_field("palette_out", want.palette, m_axis_tdata[58:43]);
        check_field("instance_count", want.instance_count, m_axis_tdata[74:59]);
        check_field("max_width", want.max_width, m_axis_tdata[90:75]);
        check_field("total_height", want.total_height, m_axis_tdata[106:91]);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL text_glyph_placement");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_layout(14, 49);
    test_random_layout(49, 14);
    test_random_layout(0, 0);
    test_receiver_stall();
    settle();
    if (mismatches == 0) $display("PASS text_glyph_placement");
    else $display("FAIL text_glyph_placement");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tgp_pkg.sv
rtl/tgp_adv_mem.sv
rtl/tgp_cursor.sv
rtl/text_glyph_placement.sv
sim/tb_text_glyph_placement.sv
